FILE: rtl/hpss_pkg.sv
// ----------------------------------------------------------------------------
// hpss_pkg
// Shared types and constants of the heater, pump and shaker sequencer.
// ----------------------------------------------------------------------------
package hpss_pkg;

   localparam int ADC_BITS_DEFAULT = 12;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] CSR_HEAT_MARGIN   = 2'd0;
   localparam logic [1:0] CSR_REVERSE_PAUSE = 2'd1;
   localparam logic [1:0] CSR_BEEP_TICKS    = 2'd2;

   localparam logic [7:0] HEAT_MARGIN_RESET   = 8'd12;
   localparam logic [9:0] REVERSE_PAUSE_RESET = 10'd100;
   localparam logic [7:0] BEEP_TICKS_RESET    = 8'd20;

   localparam logic [1:0] MOTOR_STOP = 2'd0;
   localparam logic [1:0] MOTOR_CW   = 2'd1;
   localparam logic [1:0] MOTOR_CCW  = 2'd2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_POLL = 1'b1;

   typedef struct packed {
      logic [7:0] heat_margin;
      logic [9:0] reverse_pause;
      logic [7:0] beep_ticks;
   } cfg_type;

   typedef struct packed {
      logic       heater_on;
      logic       pump_on;
      logic [1:0] motor_drive;
      logic       beeper_on;
   } rsp_type;

endpackage

FILE: rtl/hpss_if.sv
// ----------------------------------------------------------------------------
// hpss_if
// Valid/ready channels: poll and tick beats in, drive state beats out.
// ----------------------------------------------------------------------------
interface hpss_req_if
   import hpss_pkg::*;
   #(parameter int ADC_BITS = ADC_BITS_DEFAULT) ();
   logic                valid;
   logic                ready;
   logic                op;
   logic [ADC_BITS-1:0] measured_temp;
   logic [ADC_BITS-1:0] target_temp;
   logic [ADC_BITS-1:0] shake_time;
   logic [ADC_BITS-1:0] pour_time;
   logic                pour_key_level;
   logic                timed_key_level;

   modport source (output valid, op, measured_temp, target_temp, shake_time, pour_time,
                   pour_key_level, timed_key_level, input ready);
   modport sink   (input valid, op, measured_temp, target_temp, shake_time, pour_time,
                   pour_key_level, timed_key_level, output ready);
endinterface

interface hpss_rsp_if ();
   logic       valid;
   logic       ready;
   logic       heater_on;
   logic       pump_on;
   logic [1:0] motor_drive;
   logic       beeper_on;

   modport source (output valid, heater_on, pump_on, motor_drive, beeper_on, input ready);
   modport sink   (input valid, heater_on, pump_on, motor_drive, beeper_on, output ready);
endinterface

FILE: rtl/hpss_csr.sv
// ----------------------------------------------------------------------------
// hpss_csr
// APB register file: heat margin, reverse pause and beep length.
// ----------------------------------------------------------------------------
module hpss_csr
   import hpss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            CSR_HEAT_MARGIN:   cfg_in.heat_margin   = csr_pwdata[7:0];
            CSR_REVERSE_PAUSE: cfg_in.reverse_pause = csr_pwdata[9:0];
            CSR_BEEP_TICKS:    cfg_in.beep_ticks    = csr_pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_HEAT_MARGIN:   csr_prdata = {24'd0, cfg_ff.heat_margin};
         CSR_REVERSE_PAUSE: csr_prdata = {22'd0, cfg_ff.reverse_pause};
         CSR_BEEP_TICKS:    csr_prdata = {24'd0, cfg_ff.beep_ticks};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heat_margin   <= HEAT_MARGIN_RESET;
         cfg_ff.reverse_pause <= REVERSE_PAUSE_RESET;
         cfg_ff.beep_ticks    <= BEEP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/hpss_ctrl.sv
// ----------------------------------------------------------------------------
// hpss_ctrl
// Sequencer state and single-pass update for one tick or poll beat.
// ----------------------------------------------------------------------------
module hpss_ctrl
   import hpss_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                op,
   input  logic [ADC_BITS-1:0] measured_temp,
   input  logic [ADC_BITS-1:0] target_temp,
   input  logic [ADC_BITS-1:0] shake_time,
   input  logic [ADC_BITS-1:0] pour_time,
   input  logic                pour_key_level,
   input  logic                timed_key_level,
   input  cfg_type             cfg,
   output rsp_type             result
);

   localparam int PCW = ADC_BITS + 1;
   localparam int SCW = ADC_BITS + 2;
   localparam int HW  = ((ADC_BITS > 8) ? ADC_BITS : 8) + 1;
   localparam int CW  = ((SCW > 11) ? SCW : 11) + 1;
   localparam logic [PCW-1:0] POUR_MAX  = {PCW{1'b1}};
   localparam logic [SCW-1:0] SHAKE_MAX = {SCW{1'b1}};

   logic                heater_ff, heater_in;
   logic                pump_ff, pump_in;
   logic [1:0]          motor_ff, motor_in;
   logic                beeper_ff, beeper_in;
   logic                beep_act_ff, beep_act_in;
   logic [7:0]          beep_cnt_ff, beep_cnt_in;
   logic                tpour_ff, tpour_in;
   logic [PCW-1:0]      pour_cnt_ff, pour_cnt_in;
   logic                shaking_ff, shaking_in;
   logic [SCW-1:0]      shake_cnt_ff, shake_cnt_in;
   logic                pkey_arm_ff, pkey_arm_in;
   logic                tkey_arm_ff, tkey_arm_in;
   logic [ADC_BITS-1:0] shake_t_ff, shake_t_in;
   logic [ADC_BITS-1:0] pour_t_ff, pour_t_in;

   logic [8:0]     beep_inc;
   logic [CW-1:0]  t_ext, t_p, t_2, t_2p;
   logic [HW-1:0]  meas_ext, targ_ext, margin_ext;

   assign t_ext      = CW'(shake_t_ff);
   assign t_p        = t_ext + CW'(cfg.reverse_pause);
   assign t_2        = t_ext << 1;
   assign t_2p       = t_2 + CW'(cfg.reverse_pause);
   assign meas_ext   = HW'(measured_temp);
   assign targ_ext   = HW'(target_temp);
   assign margin_ext = HW'(cfg.heat_margin);
   assign beep_inc   = {1'b0, beep_cnt_ff} + 9'd1;

   always_comb begin
      logic [8:0]     bc;
      logic [PCW-1:0] pc;
      logic [SCW-1:0] sc;
      logic [CW-1:0]  sce;

      heater_in    = heater_ff;
      pump_in      = pump_ff;
      motor_in     = motor_ff;
      beeper_in    = beeper_ff;
      beep_act_in  = beep_act_ff;
      beep_cnt_in  = beep_cnt_ff;
      tpour_in     = tpour_ff;
      pour_cnt_in  = pour_cnt_ff;
      shaking_in   = shaking_ff;
      shake_cnt_in = shake_cnt_ff;
      pkey_arm_in  = pkey_arm_ff;
      tkey_arm_in  = tkey_arm_ff;
      shake_t_in   = shake_t_ff;
      pour_t_in    = pour_t_ff;
      bc           = beep_act_ff ? beep_inc : {1'b0, beep_cnt_ff};
      pc           = (tpour_ff && (pour_cnt_ff < POUR_MAX)) ? pour_cnt_ff + PCW'(1)
                                                            : pour_cnt_ff;
      sc           = (shaking_ff && (shake_cnt_ff < SHAKE_MAX)) ? shake_cnt_ff + SCW'(1)
                                                                : shake_cnt_ff;
      sce          = CW'(sc);

      if (step && (op == OP_TICK)) begin
         // advance beep, pour and shake timing
         if (bc > {1'b0, cfg.beep_ticks}) begin
            beep_act_in = 1'b0;
            beep_cnt_in = 8'd0;
         end else begin
            beep_cnt_in = bc[7:0];
         end
         pour_cnt_in = pc;
         if (pc >= PCW'(pour_t_ff)) begin
            tpour_in = 1'b0;
            pump_in  = 1'b0;
         end
         shake_cnt_in = sc;
         if (sce >= t_2p) begin
            motor_in     = MOTOR_STOP;
            shaking_in   = 1'b0;
            shake_cnt_in = '0;
         end else if (sce >= t_2) begin
            motor_in = MOTOR_STOP;
         end else if (sce >= t_p) begin
            motor_in = MOTOR_CCW;
         end else if (sce >= t_ext) begin
            motor_in = MOTOR_STOP;
         end
      end else if (step) begin
         shake_t_in = shake_time;
         pour_t_in  = pour_time;
         beeper_in  = beep_act_ff;
         if (targ_ext >= meas_ext) begin
            heater_in = 1'b0;
         end
         if ((meas_ext < margin_ext) || ((targ_ext + margin_ext) < meas_ext)) begin
            heater_in = 1'b1;
         end
         if (pour_key_level) begin
            pkey_arm_in = 1'b1;
            if (!tpour_ff) begin
               pump_in = 1'b0;
            end
         end else begin
            if (pkey_arm_ff) begin
               beep_act_in = 1'b1;
               pkey_arm_in = 1'b0;
            end
            pump_in  = 1'b1;
            tpour_in = 1'b0;
            if (!shaking_in) begin
               shaking_in   = 1'b1;
               shake_cnt_in = '0;
            end
            motor_in = MOTOR_CW;
         end
         if (!timed_key_level) begin
            tkey_arm_in = 1'b1;
         end
         if (tkey_arm_ff && timed_key_level) begin
            tkey_arm_in = 1'b0;
            tpour_in    = 1'b1;
            beep_act_in = 1'b1;
            pump_in     = 1'b1;
            if (!shaking_in) begin
               shaking_in   = 1'b1;
               shake_cnt_in = '0;
            end
            motor_in    = MOTOR_CW;
            pour_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff    <= 1'b0;
         pump_ff      <= 1'b0;
         motor_ff     <= MOTOR_STOP;
         beeper_ff    <= 1'b0;
         beep_act_ff  <= 1'b0;
         beep_cnt_ff  <= 8'd0;
         tpour_ff     <= 1'b0;
         pour_cnt_ff  <= '0;
         shaking_ff   <= 1'b0;
         shake_cnt_ff <= '0;
         pkey_arm_ff  <= 1'b0;
         tkey_arm_ff  <= 1'b0;
         shake_t_ff   <= '0;
         pour_t_ff    <= '0;
      end else begin
         heater_ff    <= heater_in;
         pump_ff      <= pump_in;
         motor_ff     <= motor_in;
         beeper_ff    <= beeper_in;
         beep_act_ff  <= beep_act_in;
         beep_cnt_ff  <= beep_cnt_in;
         tpour_ff     <= tpour_in;
         pour_cnt_ff  <= pour_cnt_in;
         shaking_ff   <= shaking_in;
         shake_cnt_ff <= shake_cnt_in;
         pkey_arm_ff  <= pkey_arm_in;
         tkey_arm_ff  <= tkey_arm_in;
         shake_t_ff   <= shake_t_in;
         pour_t_ff    <= pour_t_in;
      end
   end

   assign result.heater_on   = heater_in;
   assign result.pump_on     = pump_in;
   assign result.motor_drive = motor_in;
   assign result.beeper_on   = beeper_in;

   a_idle_shake_cleared: assert property (@(posedge clock) disable iff (reset)
      !shaking_ff |-> (shake_cnt_ff == '0))
      else $error("shake counter nonzero while no shake runs");

   a_pour_key_runs_pump: assert property (@(posedge clock) disable iff (reset)
      (step && (op == OP_POLL) && !pour_key_level) |=> (pump_ff && (motor_ff == MOTOR_CW)))
      else $error("held pour key did not run pump and clockwise shake");

   a_beeper_poll_only: assert property (@(posedge clock) disable iff (reset)
      !(step && (op == OP_POLL)) |=> $stable(beeper_ff))
      else $error("beeper changed without a poll");

   a_motor_code: assert property (@(posedge clock) disable iff (reset)
      (motor_ff != MOTOR_CCW) || shaking_ff)
      else $error("counter-clockwise drive outside a shake");

endmodule

FILE: rtl/heater_pump_shaker_sequencer_unit.sv
// ----------------------------------------------------------------------------
// heater_pump_shaker_sequencer_unit
// Appliance sequencer: heater hysteresis, manual and timed pour, shake pattern.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  req_bus | in        | op, four ADC readings, two key levels
//  rsp_bus | out       | heater_on, pump_on, motor_drive, beeper_on
//  csr_*   | in/out    | APB: heat_margin, reverse_pause, beep_ticks
//
//  One beat in, one beat out; a beat passes from accept to rsp_bus
//  through the input register and then the result register.
//  Sustained rate is one beat per cycle while rsp_bus is ready, set by the single-pass state update.
//  Reset is synchronous; the valid flags and state registers return to their reset values.
//  A stalled rsp_bus holds its beat; one more req beat is taken into the
//  input register meanwhile.
// ----------------------------------------------------------------------------
module heater_pump_shaker_sequencer_unit
   import hpss_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   hpss_req_if.sink                 req_bus,
   hpss_rsp_if.source               rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type             cfg;
   rsp_type             result;
   rsp_type             out_ff;
   logic                out_vld_ff, out_vld_in;
   logic                in_vld_ff, in_vld_in;
   logic                op_ff;
   logic [ADC_BITS-1:0] meas_ff, targ_ff, shake_ff, pour_ff;
   logic                pkey_ff, tkey_ff;
   logic                advance;
   logic                step;
   logic                req_take;

   hpss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hpss_ctrl #(.ADC_BITS(ADC_BITS)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .op              (op_ff),
      .measured_temp   (meas_ff),
      .target_temp     (targ_ff),
      .shake_time      (shake_ff),
      .pour_time       (pour_ff),
      .pour_key_level  (pkey_ff),
      .timed_key_level (tkey_ff),
      .cfg             (cfg),
      .result          (result)
   );

   assign advance       = !out_vld_ff || rsp_bus.ready;
   assign step          = in_vld_ff && advance;
   assign req_bus.ready = !in_vld_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (step) begin
         out_vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_bus.op;
         meas_ff  <= req_bus.measured_temp;
         targ_ff  <= req_bus.target_temp;
         shake_ff <= req_bus.shake_time;
         pour_ff  <= req_bus.pour_time;
         pkey_ff  <= req_bus.pour_key_level;
         tkey_ff  <= req_bus.timed_key_level;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.heater_on   = out_ff.heater_on;
   assign rsp_bus.pump_on     = out_ff.pump_on;
   assign rsp_bus.motor_drive = out_ff.motor_drive;
   assign rsp_bus.beeper_on   = out_ff.beeper_on;

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(op_ff) && $stable(meas_ff)))
      else $error("input beat lost while result stalled");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      step |=> out_vld_ff)
      else $error("result beat not loaded");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_vld_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("beat taken with both stages full");

endmodule

FILE: test/tb_heater_pump_shaker_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heater_pump_shaker_sequencer_unit
// Drives poll and tick beats through the sequencer under random backpressure
// and register settings, predicts every drive state beat in-line and checks
// the result channel field by field; register writes are read back.
// ----------------------------------------------------------------------------
module tb_heater_pump_shaker_sequencer_unit;
   import hpss_pkg::*;

   localparam int          ADC_W           = ADC_BITS_DEFAULT;
   localparam int unsigned KNOB_MAX        = (1 << ADC_W) - 1;
   localparam int unsigned POUR_CNT_LIMIT  = (1 << (ADC_W + 1)) - 1;
   localparam int unsigned SHAKE_CNT_LIMIT = (1 << (ADC_W + 2)) - 1;

   typedef struct packed {
      logic             op;
      logic [ADC_W-1:0] measured_temp;
      logic [ADC_W-1:0] target_temp;
      logic [ADC_W-1:0] shake_time;
      logic [ADC_W-1:0] pour_time;
      logic             pour_key_level;
      logic             timed_key_level;
   } req_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   hpss_req_if #(.ADC_BITS(ADC_W)) req_bus ();
   hpss_rsp_if                     rsp_bus ();

   heater_pump_shaker_sequencer_unit #(.ADC_BITS(ADC_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sequencer state as the block should hold it
   int unsigned margin_cfg = 32'(HEAT_MARGIN_RESET);
   int unsigned pause_cfg  = 32'(REVERSE_PAUSE_RESET);
   int unsigned beep_cfg   = 32'(BEEP_TICKS_RESET);
   bit          heater_st, pump_st, beeper_st;
   logic [1:0]  motor_st = MOTOR_STOP;
   bit          beep_on, timed_on, shaking_on, pour_armed, timed_armed;
   int unsigned beep_cnt, pour_cnt, shake_cnt, shake_len, pour_len;

   req_beat_type pending_beats[$];
   rsp_type      drive_expected[$];

   req_beat_type next_beat;
   req_beat_type seen_beat;
   rsp_type      want;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int req_gap_left = 0;
   int rsp_stall_left = 0;
   int long_hold_left = 0;
   int next_long_hold = 450;
   int long_holds = 0;
   int rsp_beats = 0;

   int mismatch_count = 0;
   int poll_count = 0;
   int tick_count = 0;
   int ccw_count = 0;
   int beeper_count = 0;
   int settings_count = 0;

   function automatic void begin_shake();
      if (!shaking_on) begin
         shaking_on = 1'b1;
         shake_cnt  = 0;
      end
      motor_st = MOTOR_CW;
   endfunction

   function automatic rsp_type sequencer_step(input req_beat_type b);
      int unsigned meas;
      int unsigned targ;
      rsp_type     r;
      meas = 32'(b.measured_temp);
      targ = 32'(b.target_temp);
      if (b.op == OP_POLL) begin
         shake_len = 32'(b.shake_time);
         pour_len  = 32'(b.pour_time);
         beeper_st = beep_on;
         if (targ >= meas) heater_st = 1'b0;
         if (meas < margin_cfg || targ < meas - margin_cfg) heater_st = 1'b1;
         if (b.pour_key_level) begin
            pour_armed = 1'b1;
            if (!timed_on) pump_st = 1'b0;
         end else begin
            if (pour_armed) begin
               beep_on    = 1'b1;
               pour_armed = 1'b0;
            end
            pump_st  = 1'b1;
            timed_on = 1'b0;
            begin_shake();
         end
         if (!b.timed_key_level) timed_armed = 1'b1;
         if (timed_armed && b.timed_key_level) begin
            timed_armed = 1'b0;
            timed_on    = 1'b1;
            beep_on     = 1'b1;
            pump_st     = 1'b1;
            begin_shake();
            pour_cnt    = 0;
         end
      end else begin
         if (beep_on) beep_cnt++;
         if (beep_cnt > beep_cfg) begin
            beep_on  = 1'b0;
            beep_cnt = 0;
         end
         if (timed_on && pour_cnt < POUR_CNT_LIMIT) pour_cnt++;
         if (shaking_on && shake_cnt < SHAKE_CNT_LIMIT) shake_cnt++;
         if (pour_cnt >= pour_len) begin
            timed_on = 1'b0;
            pump_st  = 1'b0;
         end
         if (shake_cnt >= shake_len) motor_st = MOTOR_STOP;
         if (shake_cnt >= shake_len + pause_cfg) motor_st = MOTOR_CCW;
         if (shake_cnt >= 2 * shake_len) motor_st = MOTOR_STOP;
         if (shake_cnt >= 2 * shake_len + pause_cfg) begin
            motor_st   = MOTOR_STOP;
            shaking_on = 1'b0;
            shake_cnt  = 0;
         end
      end
      r.heater_on   = heater_st;
      r.pump_on     = pump_st;
      r.motor_drive = motor_st;
      r.beeper_on   = beeper_st;
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_beat_type mk(input logic op, input int meas, input int targ,
                                       input int shake, input int pour,
                                       input logic pour_key, input logic timed_key);
      req_beat_type b;
      b.op              = op;
      b.measured_temp   = ADC_W'(meas);
      b.target_temp     = ADC_W'(targ);
      b.shake_time      = ADC_W'(shake);
      b.pour_time       = ADC_W'(pour);
      b.pour_key_level  = pour_key;
      b.timed_key_level = timed_key;
      return b;
   endfunction

   function automatic logic [ADC_W-1:0] knob_reading();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return ADC_W'($urandom_range(0, 24));
      if (r < 93) return ADC_W'($urandom_range(0, 400));
      return ADC_W'($urandom_range(0, KNOB_MAX));
   endfunction

   task automatic pick_temps(output logic [ADC_W-1:0] meas, output logic [ADC_W-1:0] targ);
      int m;
      int t;
      m = $urandom_range(0, KNOB_MAX);
      case ($urandom_range(0, 3))
         0: t = $urandom_range(0, KNOB_MAX);
         1: t = m + $urandom_range(0, 3);
         2: t = m - int'(margin_cfg) + $urandom_range(0, 3) - 2;
         default: begin
            m = $urandom_range(0, margin_cfg);
            t = $urandom_range(0, KNOB_MAX);
         end
      endcase
      if (t < 0) t = 0;
      if (t > int'(KNOB_MAX)) t = KNOB_MAX;
      meas = ADC_W'(m);
      targ = ADC_W'(t);
   endtask

   // one stretch of appliance use: fixed knobs, key presses in windows, some noise
   task automatic queue_session(input int count);
      int               pour_at;
      int               pour_w;
      int               timed_at;
      int               timed_w;
      int               r;
      logic [ADC_W-1:0] shake_k;
      logic [ADC_W-1:0] pour_k;
      req_beat_type     b;
      shake_k  = knob_reading();
      pour_k   = knob_reading();
      pour_at  = ($urandom_range(0, 2) == 0) ? -100 : $urandom_range(0, count - 1);
      pour_w   = $urandom_range(1, 6);
      timed_at = ($urandom_range(0, 2) == 0) ? -100 : $urandom_range(0, count - 1);
      timed_w  = $urandom_range(1, 6);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 7) begin
            b = mk(1'($urandom_range(0, 1)), $urandom_range(0, KNOB_MAX),
                   $urandom_range(0, KNOB_MAX), $urandom_range(0, KNOB_MAX),
                   $urandom_range(0, KNOB_MAX), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
         end else begin
            b.op = (r < 45) ? OP_POLL : OP_TICK;
            pick_temps(b.measured_temp, b.target_temp);
            b.shake_time      = (r % 17 == 0) ? knob_reading() : shake_k;
            b.pour_time       = pour_k;
            b.pour_key_level  = !(i >= pour_at && i < pour_at + pour_w);
            b.timed_key_level = !(i >= timed_at && i < timed_at + timed_w);
         end
         pending_beats.push_back(b);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_HEAT_MARGIN:   margin_cfg = value & 32'hFF;
         CSR_REVERSE_PAUSE: pause_cfg  = value & 32'h3FF;
         CSR_BEEP_TICKS:    beep_cfg   = value & 32'hFF;
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [1:0] idx, input string name,
                            input int unsigned value);
      logic [CSR_DATA_BITS-1:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_BITS'(idx) << 2;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== value) begin
         $error("%s: expected %0d, got %0d", name, value, got);
         mismatch_count++;
      end
   endtask

   task automatic apply_settings(input int unsigned margin, input int unsigned pause,
                                 input int unsigned beep);
      csr_write(CSR_HEAT_MARGIN, margin);
      csr_write(CSR_REVERSE_PAUSE, pause);
      csr_write(CSR_BEEP_TICKS, beep);
      csr_check(CSR_HEAT_MARGIN, "heat_margin", margin_cfg);
      csr_check(CSR_REVERSE_PAUSE, "reverse_pause", pause_cfg);
      csr_check(CSR_BEEP_TICKS, "beep_ticks", beep_cfg);
      settings_count++;
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_bus.valid || drive_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.op              = OP_TICK;
      req_bus.measured_temp   = '0;
      req_bus.target_temp     = '0;
      req_bus.shake_time      = '0;
      req_bus.pour_time       = '0;
      req_bus.pour_key_level  = 1'b1;
      req_bus.timed_key_level = 1'b1;
      rsp_bus.ready           = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_gap_left > 0) begin
            req_gap_left  <= req_gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            next_beat = pending_beats.pop_front();
            req_bus.op              <= next_beat.op;
            req_bus.measured_temp   <= next_beat.measured_temp;
            req_bus.target_temp     <= next_beat.target_temp;
            req_bus.shake_time      <= next_beat.shake_time;
            req_bus.pour_time       <= next_beat.pour_time;
            req_bus.pour_key_level  <= next_beat.pour_key_level;
            req_bus.timed_key_level <= next_beat.timed_key_level;
            req_bus.valid           <= 1'b1;
            req_gap_left            <= req_idle_on ? idle_len() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen_beat.op              = req_bus.op;
         seen_beat.measured_temp   = req_bus.measured_temp;
         seen_beat.target_temp     = req_bus.target_temp;
         seen_beat.shake_time      = req_bus.shake_time;
         seen_beat.pour_time       = req_bus.pour_time;
         seen_beat.pour_key_level  = req_bus.pour_key_level;
         seen_beat.timed_key_level = req_bus.timed_key_level;
         if (seen_beat.op == OP_POLL) poll_count++;
         else tick_count++;
         drive_expected.push_back(sequencer_step(seen_beat));
      end
   end

   // hold off for a long stretch now and then so the block backs up into req_bus
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_bus.ready  <= 1'b0;
      end else if (rsp_beats >= next_long_hold) begin
         long_hold_left <= 399;
         next_long_hold <= next_long_hold + 650;
         long_holds     <= long_holds + 1;
         rsp_bus.ready  <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_bus.ready  <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 25) begin
         rsp_stall_left <= idle_len();
         rsp_bus.ready  <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_beats <= rsp_beats + 1;
         if (drive_expected.size() == 0) begin
            $error("rsp beat: no expected result waiting");
            mismatch_count++;
         end else begin
            want = drive_expected.pop_front();
            if (want.motor_drive == MOTOR_CCW) ccw_count++;
            if (want.beeper_on) beeper_count++;
            if (rsp_bus.heater_on !== want.heater_on) begin
               $error("heater_on: expected %0d, got %0d", want.heater_on, rsp_bus.heater_on);
               mismatch_count++;
            end
            if (rsp_bus.pump_on !== want.pump_on) begin
               $error("pump_on: expected %0d, got %0d", want.pump_on, rsp_bus.pump_on);
               mismatch_count++;
            end
            if (rsp_bus.motor_drive !== want.motor_drive) begin
               $error("motor_drive: expected %0d, got %0d", want.motor_drive,
                      rsp_bus.motor_drive);
               mismatch_count++;
            end
            if (rsp_bus.beeper_on !== want.beeper_on) begin
               $error("beeper_on: expected %0d, got %0d", want.beeper_on, rsp_bus.beeper_on);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_heater_pump_shaker_sequencer_unit: errors");
      $finish;
   end

   initial begin
      int queued;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_check(CSR_HEAT_MARGIN, "heat_margin", 32'(HEAT_MARGIN_RESET));
      csr_check(CSR_REVERSE_PAUSE, "reverse_pause", 32'(REVERSE_PAUSE_RESET));
      csr_check(CSR_BEEP_TICKS, "beep_ticks", 32'(BEEP_TICKS_RESET));

      // heater rules at the default margin, manual pour, pour-end on an idle tick
      pending_beats.push_back(mk(OP_POLL, 0, 0, KNOB_MAX, KNOB_MAX, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, KNOB_MAX, 0, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, KNOB_MAX, KNOB_MAX, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 5, KNOB_MAX, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 100, 100, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 100, 88, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 100, 87, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 2000, 2000, KNOB_MAX, KNOB_MAX, 1'b0, 1'b1));
      pending_beats.push_back(mk(OP_TICK, 0, 0, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 2000, 2000, KNOB_MAX, 0, 1'b0, 1'b1));
      pending_beats.push_back(mk(OP_TICK, 0, 0, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 2000, 2000, KNOB_MAX, 0, 1'b1, 1'b1));
      wait_idle();

      // timed pour through a whole shake pattern with short pause and beep
      apply_settings(0, 2, 3);
      pending_beats.push_back(mk(OP_POLL, 0, 0, 3, 3, 1'b1, 1'b0));
      pending_beats.push_back(mk(OP_POLL, 0, 0, 3, 3, 1'b1, 1'b1));
      repeat (2) pending_beats.push_back(mk(OP_TICK, 0, 0, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 50, 40, 3, 3, 1'b1, 1'b1));
      repeat (7) pending_beats.push_back(mk(OP_TICK, 0, 0, 0, 0, 1'b1, 1'b1));
      pending_beats.push_back(mk(OP_POLL, 50, 60, 3, 3, 1'b1, 1'b1));
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: apply_settings(255, 1023, 255);
            1: apply_settings(0, 0, 0);
            default: apply_settings($urandom_range(0, 255),
                                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                                : $urandom_range(0, 12),
                                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                                : $urandom_range(0, 12));
         endcase
         req_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
         rsp_idle_on = (ph % 4 == 0) || (ph % 4 == 3);
         queued = 0;
         while (queued < 175) begin
            n = $urandom_range(10, 50);
            queue_session(n);
            queued += n;
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (drive_expected.size() != 0) begin
         $error("drive state: %0d expected results never arrived", drive_expected.size());
         mismatch_count += drive_expected.size();
      end
      $display("covered %0d polls and %0d ticks under %0d register settings",
               poll_count, tick_count, settings_count);
      $display("saw %0d counter-clockwise and %0d beeper-on states, %0d long output holds",
               ccw_count, beeper_count, long_holds);
      if (mismatch_count == 0) begin
         $display("tb_heater_pump_shaker_sequencer_unit: clean");
      end else begin
         $display("tb_heater_pump_shaker_sequencer_unit: errors");
      end
      $finish;
   end

endmodule
